[design/sph_pkg.sv]
`timescale 1ns / 1ps

package sph_pkg;

    // Width of the instruction counter absorbed at the end of a program
    localparam int unsigned COUNT_BITS = 32;

    localparam logic [63:0] KEY_LOW_RESET  = 64'h3df52ab9c5671a23;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h7a8321f0bc9a8533;
    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    // Operand forms carried in tuser
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_IMM  = 2'd3;

    // Register byte addresses (bit 3 selects the key word)
    localparam logic ADDR_KEY_LOW  = 1'b0;
    localparam logic ADDR_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_sip_state;

    // Handoff from the absorb stage to the finalization pipe
    typedef struct packed {
        t_sip_state            st;
        logic [COUNT_BITS-1:0] count;
    } t_fin_req;

    function automatic t_sip_state sip_init(input logic [63:0] klo, input logic [63:0] khi);
        t_sip_state s;
        s.v0 = klo ^ IV0;
        s.v1 = khi ^ IV1;
        s.v2 = klo ^ IV2;
        s.v3 = khi ^ IV3;
        return s;
    endfunction

    function automatic t_sip_state sip_round(input t_sip_state s_in);
        t_sip_state s;
        s = s_in;
        s.v0 = s.v0 + s.v1;
        s.v1 = {s.v1[50:0], s.v1[63:51]};
        s.v1 = s.v1 ^ s.v0;
        s.v0 = {s.v0[31:0], s.v0[63:32]};
        s.v2 = s.v2 + s.v3;
        s.v3 = {s.v3[47:0], s.v3[63:48]};
        s.v3 = s.v3 ^ s.v2;
        s.v2 = s.v2 + s.v1;
        s.v1 = {s.v1[46:0], s.v1[63:47]};
        s.v1 = s.v1 ^ s.v2;
        s.v2 = {s.v2[31:0], s.v2[63:32]};
        s.v0 = s.v0 + s.v3;
        s.v3 = {s.v3[42:0], s.v3[63:43]};
        s.v3 = s.v3 ^ s.v0;
        return s;
    endfunction

    // Absorb one message word with two rounds
    function automatic t_sip_state sip_absorb(input t_sip_state s_in, input logic [63:0] m);
        t_sip_state s;
        s = s_in;
        s.v3 = s.v3 ^ m;
        s = sip_round(sip_round(s));
        s.v0 = s.v0 ^ m;
        return s;
    endfunction

endpackage

[design/siphash_program_hasher.sv]
`timescale 1ns / 1ps
// Throughput: one instruction word per cycle, set by the two-round absorb loop on v0..v3,
// unless a last word waits for the finalization pipe; a word is registered, then absorbed.
// A last word leaves through a three-stage finalization pipe and an output register,
// which holds its digest; the next program may follow at once.
// Reset (synchronous, active low) loads the default keys and the matching initial state.
module siphash_program_hasher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Instruction stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // opcode[15:0], dest_reg[31:16], src_first[47:32],
                                         // src_second[63:48], imm_upper[95:64]
    input  logic [1:0]   s_axis_tuser,   // kind[1:0]
    input  logic         s_axis_tlast,
    // Digest stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // digest[63:0]
    // Key registers
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import sph_pkg::*;

    logic [63:0]           r_key_low;
    logic [63:0]           r_key_high;
    logic [63:0]           n_key_low;
    logic [63:0]           n_key_high;
    logic                  r_in_valid;
    logic [63:0]           r_in_word;
    logic                  r_in_last;
    t_sip_state            r_st;
    t_sip_state            n_st;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  r_busy;
    logic                  n_busy;

    logic        w_cfg_wr;
    logic        w_in_take;
    logic        w_in_adv;
    logic        w_fin_ready;
    logic [63:0] w_word;
    t_sip_state  w_abs;
    t_fin_req    w_req;

    // Key registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[3] == ADDR_KEY_HIGH) ? r_key_high : r_key_low;

    always_comb begin
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        if (w_cfg_wr) begin
            if (paddr[3] == ADDR_KEY_LOW) begin
                n_key_low = pwdata;
            end else begin
                n_key_high = pwdata;
            end
        end
    end

    // Pack the instruction into its 64-bit message word
    always_comb begin
        w_word = {s_axis_tdata[15:0], s_axis_tdata[31:16], 32'd0};
        case (s_axis_tuser)
            KIND_NONE: w_word = w_word;
            KIND_ONE:  w_word[31:16] = s_axis_tdata[47:32];
            KIND_TWO:  w_word[31:0] = {s_axis_tdata[47:32], s_axis_tdata[63:48]};
            KIND_IMM:  w_word[31:0] = s_axis_tdata[95:64];
            default:   w_word = w_word;
        endcase
    end

    // Input register drains unless a last word waits for the finalization pipe
    assign w_in_adv      = r_in_valid && (!r_in_last || w_fin_ready);
    assign s_axis_tready = !r_in_valid || w_in_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    // Absorb the registered word; a last word hands its state to finalization
    always_comb begin
        w_abs     = sip_absorb(r_st, r_in_word);
        w_req.st  = w_abs;
        w_req.count = r_cnt + 1'b1;
        n_st      = r_st;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        if (w_in_adv) begin
            if (r_in_last) begin
                n_st   = sip_init(n_key_low, n_key_high);
                n_cnt  = '0;
                n_busy = 1'b0;
            end else begin
                n_st   = w_abs;
                n_cnt  = r_cnt + 1'b1;
                n_busy = 1'b1;
            end
        end else if (w_cfg_wr && !r_busy) begin
            n_st = sip_init(n_key_low, n_key_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= KEY_LOW_RESET;
            r_key_high <= KEY_HIGH_RESET;
            r_st       <= sip_init(KEY_LOW_RESET, KEY_HIGH_RESET);
            r_cnt      <= '0;
            r_busy     <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            r_st       <= n_st;
            r_cnt      <= n_cnt;
            r_busy     <= n_busy;
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
        end
    end

    // Hold the word until the absorb stage takes it
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= w_word;
            r_in_last <= s_axis_tlast;
        end
    end

    sph_fin_pipe u_fin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (r_in_valid && r_in_last),
        .i_req         (w_req),
        .o_req_ready   (w_fin_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[design/sph_fin_pipe.sv]
`timescale 1ns / 1ps

module sph_fin_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  sph_pkg::t_fin_req   i_req,
    output logic                o_req_ready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata     // digest[63:0]
);
    import sph_pkg::*;

    logic                  r_f1_valid;
    t_sip_state            r_f1_st;
    logic [COUNT_BITS-1:0] r_f1_cnt;
    logic                  r_f2_valid;
    t_sip_state            r_f2_st;
    logic                  r_f3_valid;
    t_sip_state            r_f3_st;
    logic                  r_out_valid;
    logic [63:0]           r_digest;

    logic       w_out_free;
    logic       w_f3_free;
    logic       w_f2_free;
    logic       w_f1_free;
    t_sip_state n_f2_st;
    t_sip_state n_f3_st;
    t_sip_state w_last_st;

    // A stage may load when it is empty or its word moves on
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_f3_free   = !r_f3_valid || w_out_free;
    assign w_f2_free   = !r_f2_valid || w_f3_free;
    assign w_f1_free   = !r_f1_valid || w_f2_free;
    assign o_req_ready = w_f1_free;

    // Absorb the count and mark finalization, then two rounds per stage
    always_comb begin
        n_f2_st    = sip_absorb(r_f1_st, 64'(r_f1_cnt));
        n_f2_st.v2 = n_f2_st.v2 ^ FINAL_XOR;
        n_f3_st    = sip_round(sip_round(r_f2_st));
        w_last_st  = sip_round(sip_round(r_f3_st));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_f3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_f1_free) begin
                r_f1_valid <= i_req_valid;
            end
            if (w_f2_free) begin
                r_f2_valid <= r_f1_valid;
            end
            if (w_f3_free) begin
                r_f3_valid <= r_f2_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_f3_valid;
            end
        end
    end

    // Payload follows its stage enable
    always_ff @(posedge i_clk) begin
        if (w_f1_free) begin
            r_f1_st  <= i_req.st;
            r_f1_cnt <= i_req.count;
        end
        if (w_f2_free) begin
            r_f2_st <= n_f2_st;
        end
        if (w_f3_free) begin
            r_f3_st <= n_f3_st;
        end
        if (w_out_free) begin
            r_digest <= w_last_st.v0 ^ w_last_st.v1 ^ w_last_st.v2 ^ w_last_st.v3;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_digest;

endmodule
